### rtl/core/dma_pkg.sv
// ----------------------------------------------------------------------------
// Droplet moment accumulator package
// Widths, state and command codes, and the control and status structs shared
// by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package dma_pkg;

    // Field widths of one cell and of one droplet result.
    localparam int VOL_W   = 24;
    localparam int FILL_W  = 17;
    localparam int COORD_W = 24;
    localparam int DENS_W  = 16;
    localparam int LV_W    = 24;
    localparam int CM_W    = 40;
    localparam int VSUM_W  = 40;
    localparam int MSUM_W  = 56;
    localparam int MOM_W   = 64;
    localparam int MEAN_W  = 24;
    localparam int FRAC_W  = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 240;

    // Six coordinates per cell: x, y, z, u, v, w.
    localparam int NUM_LANES = 6;
    localparam int LANE_W    = 3;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);

    // Shared multiplier: 25-bit signed by 21-bit signed operands.
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 21;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int CM_SPLIT = 20;

    // Mean divider: 23 quotient bits (7 integer, 16 fractional).
    localparam int QUO_W     = 23;
    localparam int INT_W     = QUO_W - FRAC_W;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);
    localparam int REM_W     = MSUM_W;

    localparam logic [DENS_W-1:0] DENSITY_RESET = DENS_W'(997);
    localparam logic [FILL_W-1:0] FULL_FILL     = FILL_W'(65536);

    localparam logic [MOM_W-1:0]  MOM_MAX  = {1'b0, {(MOM_W-1){1'b1}}};
    localparam logic [MOM_W-1:0]  MOM_MIN  = {1'b1, {(MOM_W-1){1'b0}}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LV,
        ST_MUL_CM,
        ST_MASS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMB,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_DONE,
        ST_EMIT
    } dma_state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_LV,
        OP_MUL_CM,
        OP_MASS,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_COMB,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_EMIT
    } dma_op_t;

    typedef struct packed {
        dma_op_t           op;
        logic [LANE_W-1:0] lane;
    } dma_cmd_t;

    typedef struct packed {
        logic out_full;
        logic last_cell;
    } dma_status_t;

endpackage

### rtl/core/droplet_moment_accumulator.sv
// Sequencing: each cell is taken in idle, then runs through the volume and mass products and the six
// moment lanes one after another; the last cell of a droplet then runs the six means one after another
// through a 23-step restoring divider before the result is emitted, and emit waits on m_tready.
// Throughput: no new cell is taken until the previous one, with any divisions and its emit, is complete.
// Reset: aresetn is synchronous and active low; it clears all sums and restores density 997.
// ----------------------------------------------------------------------------
// Droplet moment accumulator
// Accumulates liquid volume, mass and mass-weighted centroid and velocity
// moments over the cells of one droplet and emits totals and means.
// ----------------------------------------------------------------------------
module droplet_moment_accumulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Cell input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: cell_volume, fill_fraction, centroid_x, centroid_y,
    // centroid_z, velocity_u, velocity_v, velocity_w, zero padding.
    input  logic [dma_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,    // start_droplet
    input  logic                                s_tlast,    // end_droplet
    // Density register write.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dma_pkg::DENS_W-1:0]          cfg_data,   // liquid_density
    // Droplet result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: total_volume, total_mass, mean_x, mean_y, mean_z,
    // mean_u, mean_v, mean_w.
    output logic [dma_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser     // zero_mass
);

    dma_pkg::dma_cmd_t    cmd;
    dma_pkg::dma_status_t status;
    logic                 cfg_we;

    // The density register takes a write in any cycle out of reset.
    assign cfg_ready = aresetn;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Sequencer.
    dma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    dma_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/dma_ctrl.sv
// ----------------------------------------------------------------------------
// Droplet moment accumulator controller
// Sequences one cell through the shared multiplier and the six moment lanes,
// and on the last cell of a droplet through the six mean divisions.
// ----------------------------------------------------------------------------
module dma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dma_pkg::dma_status_t status,
    output dma_pkg::dma_cmd_t    cmd
);

    dma_pkg::dma_state_t              state_reg, state_next;
    logic [dma_pkg::LANE_W-1:0]       lane_reg, lane_next;
    logic [dma_pkg::STEP_W-1:0]       step_reg, step_next;

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dma_pkg::ST_IDLE;
            lane_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            step_reg  <= step_next;
        end
    end

    // Next state, lane and division step.
    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        step_next  = step_reg;
        case (state_reg)
            dma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = dma_pkg::ST_MUL_LV;
                end
            end
            dma_pkg::ST_MUL_LV: begin
                state_next = dma_pkg::ST_MUL_CM;
            end
            dma_pkg::ST_MUL_CM: begin
                state_next = dma_pkg::ST_MASS;
            end
            dma_pkg::ST_MASS: begin
                state_next = dma_pkg::ST_MUL_LO;
                lane_next  = '0;
            end
            dma_pkg::ST_MUL_LO: begin
                state_next = dma_pkg::ST_MUL_HI;
            end
            dma_pkg::ST_MUL_HI: begin
                state_next = dma_pkg::ST_COMB;
            end
            dma_pkg::ST_COMB: begin
                state_next = dma_pkg::ST_ACC;
            end
            dma_pkg::ST_ACC: begin
                if (lane_reg != dma_pkg::LAST_LANE) begin
                    state_next = dma_pkg::ST_MUL_LO;
                    lane_next  = lane_reg + 3'd1;
                end else if (status.last_cell) begin
                    state_next = dma_pkg::ST_DIV_INIT;
                    lane_next  = '0;
                end else begin
                    state_next = dma_pkg::ST_IDLE;
                end
            end
            dma_pkg::ST_DIV_INIT: begin
                state_next = dma_pkg::ST_DIV_STEP;
                step_next  = '0;
            end
            dma_pkg::ST_DIV_STEP: begin
                if (step_reg == dma_pkg::LAST_STEP) begin
                    state_next = dma_pkg::ST_DIV_DONE;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            dma_pkg::ST_DIV_DONE: begin
                if (lane_reg == dma_pkg::LAST_LANE) begin
                    state_next = dma_pkg::ST_EMIT;
                end else begin
                    state_next = dma_pkg::ST_DIV_INIT;
                    lane_next  = lane_reg + 3'd1;
                end
            end
            dma_pkg::ST_EMIT: begin
                if (!status.out_full) begin
                    state_next = dma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dma_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath; no beat is taken while reset is held.
    always_comb begin
        s_tready = 1'b0;
        cmd.lane = lane_reg;
        cmd.op   = dma_pkg::OP_NONE;
        case (state_reg)
            dma_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    cmd.op = dma_pkg::OP_LOAD;
                end
            end
            dma_pkg::ST_MUL_LV:   cmd.op = dma_pkg::OP_MUL_LV;
            dma_pkg::ST_MUL_CM:   cmd.op = dma_pkg::OP_MUL_CM;
            dma_pkg::ST_MASS:     cmd.op = dma_pkg::OP_MASS;
            dma_pkg::ST_MUL_LO:   cmd.op = dma_pkg::OP_MUL_LO;
            dma_pkg::ST_MUL_HI:   cmd.op = dma_pkg::OP_MUL_HI;
            dma_pkg::ST_COMB:     cmd.op = dma_pkg::OP_COMB;
            dma_pkg::ST_ACC:      cmd.op = dma_pkg::OP_ACC;
            dma_pkg::ST_DIV_INIT: cmd.op = dma_pkg::OP_DIV_INIT;
            dma_pkg::ST_DIV_STEP: cmd.op = dma_pkg::OP_DIV_STEP;
            dma_pkg::ST_DIV_DONE: cmd.op = dma_pkg::OP_DIV_DONE;
            dma_pkg::ST_EMIT: begin
                if (!status.out_full) begin
                    cmd.op = dma_pkg::OP_EMIT;
                end
            end
            default: cmd.op = dma_pkg::OP_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // The lane counter never leaves the six coordinates.
    a_lane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_reg <= dma_pkg::LAST_LANE)
        else $error("lane counter out of range");

    // The division step counter stays within the quotient width.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= dma_pkg::LAST_STEP)
        else $error("division step counter out of range");

    // A cell beat is taken only while the controller is idle.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (state_reg == dma_pkg::ST_IDLE))
        else $error("s_tready raised outside the idle state");
`endif

endmodule

### rtl/core/dma_datapath.sv
// ----------------------------------------------------------------------------
// Droplet moment accumulator datapath
// Input capture, shared multiplier, saturating sums, the bit-serial mean
// divider and the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
module dma_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Fields from bit 0: cell_volume, fill_fraction, centroid_x, centroid_y,
    // centroid_z, velocity_u, velocity_v, velocity_w, zero padding.
    input  logic [dma_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,    // start_droplet
    input  logic                                s_tlast,    // end_droplet
    input  logic                                cfg_we,
    input  logic [dma_pkg::DENS_W-1:0]          cfg_data,
    input  dma_pkg::dma_cmd_t                   cmd,
    output dma_pkg::dma_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: total_volume, total_mass, mean_x, mean_y, mean_z,
    // mean_u, mean_v, mean_w.
    output logic [dma_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser     // zero_mass
);

    localparam int VW = dma_pkg::VOL_W;
    localparam int FW = dma_pkg::FILL_W;
    localparam int CW = dma_pkg::COORD_W;

    // Configuration and captured cell.
    logic [dma_pkg::DENS_W-1:0]          density_reg;
    logic [VW-1:0]                       vol_reg;
    logic [FW-1:0]                       fill_reg;
    logic [CW-1:0]                       coord_reg [dma_pkg::NUM_LANES];
    logic                                last_reg;

    // Multiplier and product registers.
    logic signed [dma_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [dma_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [dma_pkg::MUL_P_W-1:0]  mul_next;
    logic signed [dma_pkg::MUL_P_W-1:0]  mul_reg;
    logic signed [dma_pkg::MUL_P_W-1:0]  lo_reg;
    logic [dma_pkg::CM_W-1:0]            cm_reg;
    logic signed [dma_pkg::MOM_W-1:0]    prod_reg;

    // Running sums.
    logic [dma_pkg::VSUM_W-1:0]          vsum_reg;
    logic [dma_pkg::MSUM_W-1:0]          msum_reg;
    logic [dma_pkg::MOM_W-1:0]           mom_reg [dma_pkg::NUM_LANES];

    // Divider.
    logic                                neg_reg;
    logic                                sat_reg;
    logic [dma_pkg::REM_W-1:0]           rem_reg;
    logic [dma_pkg::QUO_W-1:0]           dvd_reg;
    logic [dma_pkg::QUO_W-1:0]           quo_reg;
    logic [dma_pkg::MEAN_W-1:0]          mean_reg [dma_pkg::NUM_LANES];

    // Output register.
    logic                                out_valid_reg;
    logic [dma_pkg::OUT_TDATA_W-1:0]     out_data_reg;
    logic                                out_zero_reg;

    // Combinational helpers.
    logic [FW-1:0]                       fill_in;
    logic [CW-1:0]                       coord_sel;
    logic [dma_pkg::LV_W-1:0]            lv;
    logic [dma_pkg::VSUM_W:0]            vsum_add;
    logic [dma_pkg::MSUM_W:0]            msum_add;
    logic [dma_pkg::MOM_W-1:0]           lo_ext;
    logic [dma_pkg::MOM_W-1:0]           hi_ext;
    logic [dma_pkg::MOM_W-1:0]           prod_next;
    logic [dma_pkg::MOM_W-1:0]           mom_cur;
    logic [dma_pkg::MOM_W-1:0]           contrib;
    logic [dma_pkg::MOM_W-1:0]           acc_sum;
    logic                                acc_ovf;
    logic [dma_pkg::MOM_W-1:0]           acc_next;
    logic [dma_pkg::MOM_W-1:0]           mag;
    logic [dma_pkg::MOM_W-1:0]           sat_lim;
    logic [dma_pkg::REM_W:0]             trial;
    logic [dma_pkg::REM_W:0]             diff;
    logic                                trial_ge;
    logic [dma_pkg::MEAN_W-1:0]          mean_mag;
    logic [dma_pkg::MEAN_W-1:0]          mean_next;
    logic                                mass_zero;

    assign fill_in   = s_tdata[VW +: FW];
    assign coord_sel = coord_reg[cmd.lane];
    assign lv        = mul_reg[dma_pkg::FRAC_W +: dma_pkg::LV_W];
    assign mass_zero = (msum_reg == '0);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            dma_pkg::OP_MUL_LV: begin
                mul_a = {1'b0, vol_reg};
                mul_b = {{(dma_pkg::MUL_B_W-FW){1'b0}}, fill_reg};
            end
            dma_pkg::OP_MUL_CM: begin
                mul_a = {1'b0, lv};
                mul_b = {{(dma_pkg::MUL_B_W-dma_pkg::DENS_W){1'b0}}, density_reg};
            end
            dma_pkg::OP_MUL_LO: begin
                mul_a = {coord_sel[CW-1], coord_sel};
                mul_b = {1'b0, cm_reg[dma_pkg::CM_SPLIT-1:0]};
            end
            dma_pkg::OP_MUL_HI: begin
                mul_a = {coord_sel[CW-1], coord_sel};
                mul_b = {1'b0, cm_reg[dma_pkg::CM_W-1:dma_pkg::CM_SPLIT]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_next = mul_a * mul_b;

    // Volume and mass sums saturate at their full width.
    assign vsum_add = {1'b0, vsum_reg} + (dma_pkg::VSUM_W+1)'(lv);
    assign msum_add = {1'b0, msum_reg} + (dma_pkg::MSUM_W+1)'(mul_reg[dma_pkg::CM_W-1:0]);

    // Full product from the two partial products.
    assign lo_ext    = {{(dma_pkg::MOM_W-dma_pkg::MUL_P_W){lo_reg[dma_pkg::MUL_P_W-1]}}, lo_reg};
    assign hi_ext    = {{(dma_pkg::MOM_W-dma_pkg::MUL_P_W){mul_reg[dma_pkg::MUL_P_W-1]}},
                        mul_reg};
    assign prod_next = lo_ext + {hi_ext[dma_pkg::MOM_W-dma_pkg::CM_SPLIT-1:0],
                                 {dma_pkg::CM_SPLIT{1'b0}}};

    // Flooring shift of the product and saturating signed moment add.
    assign mom_cur  = mom_reg[cmd.lane];
    assign contrib  = dma_pkg::MOM_W'(prod_reg >>> dma_pkg::FRAC_W);
    assign acc_sum  = mom_cur + contrib;
    assign acc_ovf  = (mom_cur[dma_pkg::MOM_W-1] == contrib[dma_pkg::MOM_W-1])
                   && (acc_sum[dma_pkg::MOM_W-1] != mom_cur[dma_pkg::MOM_W-1]);
    assign acc_next = !acc_ovf ? acc_sum
                    : (mom_cur[dma_pkg::MOM_W-1] ? dma_pkg::MOM_MIN : dma_pkg::MOM_MAX);

    // Divider setup: magnitude and the quotient overflow test against mass * 128.
    assign mag     = mom_cur[dma_pkg::MOM_W-1] ? (~mom_cur + 64'd1) : mom_cur;
    assign sat_lim = {1'b0, msum_reg, {dma_pkg::INT_W{1'b0}}};

    // One restoring division step per cycle.
    assign trial    = {rem_reg, dvd_reg[dma_pkg::QUO_W-1]};
    assign diff     = trial - {1'b0, msum_reg};
    assign trial_ge = (trial >= {1'b0, msum_reg});

    // Final mean: zero mass, saturation, then the sign.
    assign mean_mag = {1'b0, quo_reg};
    always_comb begin
        if (mass_zero) begin
            mean_next = '0;
        end else if (sat_reg) begin
            mean_next = neg_reg ? dma_pkg::MEAN_MIN : dma_pkg::MEAN_MAX;
        end else if (neg_reg) begin
            mean_next = ~mean_mag + 24'd1;
        end else begin
            mean_next = mean_mag;
        end
    end

    // Density register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            density_reg <= dma_pkg::DENSITY_RESET;
        end else if (cfg_we) begin
            density_reg <= cfg_data;
        end
    end

    // Cell capture, multiplier and divider registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            dma_pkg::OP_LOAD: begin
                vol_reg  <= s_tdata[VW-1:0];
                fill_reg <= (fill_in > dma_pkg::FULL_FILL) ? dma_pkg::FULL_FILL : fill_in;
                for (int i = 0; i < dma_pkg::NUM_LANES; i++) begin
                    coord_reg[i] <= s_tdata[VW + FW + i*CW +: CW];
                end
            end
            dma_pkg::OP_MUL_LV, dma_pkg::OP_MUL_CM: begin
                mul_reg <= mul_next;
            end
            dma_pkg::OP_MASS: begin
                cm_reg <= mul_reg[dma_pkg::CM_W-1:0];
            end
            dma_pkg::OP_MUL_LO: begin
                mul_reg <= mul_next;
            end
            dma_pkg::OP_MUL_HI: begin
                lo_reg  <= mul_reg;
                mul_reg <= mul_next;
            end
            dma_pkg::OP_COMB: begin
                prod_reg <= prod_next;
            end
            dma_pkg::OP_DIV_INIT: begin
                neg_reg <= mom_cur[dma_pkg::MOM_W-1];
                sat_reg <= (mag >= sat_lim);
                rem_reg <= mag[dma_pkg::MOM_W-2:dma_pkg::INT_W];
                dvd_reg <= {mag[dma_pkg::INT_W-1:0], {dma_pkg::FRAC_W{1'b0}}};
                quo_reg <= '0;
            end
            dma_pkg::OP_DIV_STEP: begin
                rem_reg <= trial_ge ? diff[dma_pkg::REM_W-1:0] : trial[dma_pkg::REM_W-1:0];
                dvd_reg <= {dvd_reg[dma_pkg::QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[dma_pkg::QUO_W-2:0], trial_ge};
            end
            dma_pkg::OP_DIV_DONE: begin
                mean_reg[cmd.lane] <= mean_next;
            end
            default: begin
            end
        endcase
    end

    // Droplet state: end flag and the saturating sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= 1'b0;
            vsum_reg <= '0;
            msum_reg <= '0;
            for (int i = 0; i < dma_pkg::NUM_LANES; i++) begin
                mom_reg[i] <= '0;
            end
        end else begin
            case (cmd.op)
                dma_pkg::OP_LOAD: begin
                    last_reg <= s_tlast;
                    if (s_tuser) begin
                        vsum_reg <= '0;
                        msum_reg <= '0;
                        for (int i = 0; i < dma_pkg::NUM_LANES; i++) begin
                            mom_reg[i] <= '0;
                        end
                    end
                end
                dma_pkg::OP_MUL_CM: begin
                    vsum_reg <= vsum_add[dma_pkg::VSUM_W] ? {dma_pkg::VSUM_W{1'b1}}
                                                         : vsum_add[dma_pkg::VSUM_W-1:0];
                end
                dma_pkg::OP_MASS: begin
                    msum_reg <= msum_add[dma_pkg::MSUM_W] ? {dma_pkg::MSUM_W{1'b1}}
                                                         : msum_add[dma_pkg::MSUM_W-1:0];
                end
                dma_pkg::OP_ACC: begin
                    mom_reg[cmd.lane] <= acc_next;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: loaded on emit, emptied when the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == dma_pkg::OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == dma_pkg::OP_EMIT) begin
            out_data_reg <= {mean_reg[5], mean_reg[4], mean_reg[3], mean_reg[2],
                             mean_reg[1], mean_reg[0], msum_reg, vsum_reg};
            out_zero_reg <= mass_zero;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;
    assign m_tuser          = out_zero_reg;
    assign status.out_full  = out_valid_reg && !m_tready;
    assign status.last_cell = last_reg;

`ifndef NO_ASSERTIONS
    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == dma_pkg::OP_EMIT) |-> !(out_valid_reg && !m_tready))
        else $error("result register overwritten before the beat was taken");

    // An emit always presents a beat in the next cycle.
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == dma_pkg::OP_EMIT) |=> m_tvalid)
        else $error("emit did not raise m_tvalid");

    // A zero-mass result carries all six means as zero.
    a_zero_means: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[dma_pkg::OUT_TDATA_W-1:96] == '0))
        else $error("zero-mass result with nonzero means");
`endif

endmodule
